// File: hw/rtl/slnp_pkg.sv
// Shared types and constants of the slot/name list parser.
// Used by every module under hw/rtl; depends on nothing.
package slnp_pkg;

	localparam int SLOT_COUNT_DEF  = 2;
	localparam int MAX_PAYLOAD_DEF = 65535;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int CNT_W           = 14;

	typedef enum logic [1:0] {
		KIND_CHAR = 2'd0,
		KIND_END  = 2'd1,
		KIND_SUM  = 2'd2
	} kind_t;

	// Everything one input byte causes: an optional entry result, then an optional summary.
	typedef struct packed {
		logic             has_prim;
		logic             prim_end;
		logic [7:0]       slot;
		logic [7:0]       name_char;
		logic             name_present;
		logic             has_sum;
		logic             valid_res;
		logic [31:0]      declared;
		logic [CNT_W-1:0] parsed;
		logic [CNT_W-1:0] accepted;
		logic [CNT_W-1:0] rejected;
	} evt_t;

endpackage

// File: hw/rtl/slot_name_list_parser.sv
// Top level of the slot/name list parser: front parser, record queue and output back end.
// Depends on slnp_pkg, slnp_front, slnp_queue and slnp_back.
//
//   channel   handshake          payload
//   input     push / full        data_byte, last_byte, frame_len
//   result    pop / empty        kind, slot, name_char, name_present, valid_res,
//                                declared_count, parsed_count, accepted_count,
//                                rejected_count, last_result
//
// One input byte is taken per cycle while the record queue has room; a result beat is
// written to the queue and shows up on the ports once the records ahead of it are popped.
// A byte that causes two results occupies the output side for two beats, so output pop
// rate sets sustained throughput. full rises only when QUEUE_DEPTH records wait unread.
// arst_n clears the parser to the header phase and empties the queue.
module slot_name_list_parser #(
	parameter int SLOT_COUNT  = slnp_pkg::SLOT_COUNT_DEF,
	parameter int MAX_PAYLOAD = slnp_pkg::MAX_PAYLOAD_DEF,
	parameter int QUEUE_DEPTH = slnp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic [7:0]                 data_byte,
	input  logic                       last_byte,
	input  logic [15:0]                frame_len,
	output logic                       empty,
	input  logic                       pop,
	output logic [1:0]                 kind,
	output logic [7:0]                 slot,
	output logic [7:0]                 name_char,
	output logic                       name_present,
	output logic                       valid_res,
	output logic [31:0]                declared_count,
	output logic [slnp_pkg::CNT_W-1:0] parsed_count,
	output logic [slnp_pkg::CNT_W-1:0] accepted_count,
	output logic [slnp_pkg::CNT_W-1:0] rejected_count,
	output logic                       last_result
);

	slnp_pkg::evt_t new_evt, head_evt;
	logic           take, evt_push, q_rd;

	assign take = push && !full;

	slnp_front #(
		.SLOT_COUNT (SLOT_COUNT),
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.frame_len(frame_len),
		.evt_push (evt_push),
		.evt      (new_evt)
	);

	slnp_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (evt_push),
		.wr_evt (new_evt),
		.rd_en  (q_rd),
		.rd_evt (head_evt),
		.q_full (full),
		.q_empty(empty)
	);

	slnp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head_evt),
		.q_empty       (empty),
		.pop           (pop),
		.q_rd          (q_rd),
		.kind          (kind),
		.slot          (slot),
		.name_char     (name_char),
		.name_present  (name_present),
		.valid_res     (valid_res),
		.declared_count(declared_count),
		.parsed_count  (parsed_count),
		.accepted_count(accepted_count),
		.rejected_count(rejected_count),
		.last_result   (last_result)
	);

endmodule

// File: hw/rtl/slnp_front.sv
// Front end of the parser: takes one payload byte a cycle while take is high, walks the
// header and entries, and builds the result record for the queue. Depends on slnp_pkg.
module slnp_front #(
	parameter int SLOT_COUNT  = slnp_pkg::SLOT_COUNT_DEF,
	parameter int MAX_PAYLOAD = slnp_pkg::MAX_PAYLOAD_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	input  logic [15:0]       frame_len,
	output logic              evt_push,
	output slnp_pkg::evt_t    evt
);

	typedef enum logic [4:0] {
		PH_HEADER = 5'b00001,
		PH_SLOT   = 5'b00010,
		PH_NAME   = 5'b00100,
		PH_DONE   = 5'b01000,
		PH_BAD    = 5'b10000
	} phase_t;

	localparam int CW = slnp_pkg::CNT_W;

	phase_t         phase_q, phase_d;
	logic [1:0]     pos_q, pos_d;
	logic [31:0]    hc_q, hc_d, hc_asm;
	logic [7:0]     slot_lo_q, slot_lo_d;
	logic           slot_hi_q, slot_hi_d;
	logic           slot_ok_q, slot_ok_d;
	logic           seen_q, seen_d;
	logic [CW-1:0]  parsed_q, parsed_d;
	logic [CW-1:0]  accepted_q, accepted_d;
	logic [CW-1:0]  rejected_q, rejected_d;
	logic [15:0]    len_c;
	logic [34:0]    hc_x5;
	logic           byte_nz;

	assign byte_nz = (data_byte != 8'd0);
	assign len_c = (frame_len > 16'(MAX_PAYLOAD)) ? 16'(MAX_PAYLOAD) : frame_len;
	// count > (len - 4) / 5 holds exactly when 5 * count > len - 4.
	assign hc_x5 = {1'b0, hc_asm, 2'b00} + {3'b000, hc_asm};

	always_comb begin
		hc_asm = hc_q;
		case (pos_q)
			2'd0: hc_asm[7:0]   = data_byte;
			2'd1: hc_asm[15:8]  = data_byte;
			2'd2: hc_asm[23:16] = data_byte;
			2'd3: hc_asm[31:24] = data_byte;
			default: hc_asm = hc_q;
		endcase
	end

	always_comb begin
		phase_d    = phase_q;
		pos_d      = pos_q;
		hc_d       = hc_q;
		slot_lo_d  = slot_lo_q;
		slot_hi_d  = slot_hi_q;
		slot_ok_d  = slot_ok_q;
		seen_d     = seen_q;
		parsed_d   = parsed_q;
		accepted_d = accepted_q;
		rejected_d = rejected_q;
		evt        = '0;

		case (phase_q)
			PH_HEADER: begin
				hc_d  = hc_asm;
				pos_d = pos_q + 2'd1;
				if (pos_q == 2'd3) begin
					if (len_c < 16'd4) begin
						hc_d    = '0;
						phase_d = PH_BAD;
					end else if (hc_x5 > {19'd0, len_c - 16'd4}) begin
						phase_d = PH_BAD;
					end else if (hc_asm == 32'd0) begin
						phase_d = PH_DONE;
					end else begin
						phase_d = PH_SLOT;
					end
				end
			end
			PH_SLOT: begin
				pos_d = pos_q + 2'd1;
				if (pos_q == 2'd0) begin
					slot_lo_d = data_byte;
					slot_hi_d = 1'b0;
				end else begin
					slot_hi_d = slot_hi_q | byte_nz;
				end
				if (pos_q == 2'd3) begin
					slot_ok_d = !(slot_hi_q | byte_nz) && ({1'b0, slot_lo_q} < 9'(SLOT_COUNT));
					seen_d    = 1'b0;
					phase_d   = PH_NAME;
				end
			end
			PH_NAME: begin
				if (byte_nz) begin
					seen_d = 1'b1;
					if (slot_ok_q) begin
						evt.has_prim  = 1'b1;
						evt.slot      = slot_lo_q;
						evt.name_char = data_byte;
					end
				end else begin
					parsed_d = parsed_q + CW'(1);
					if (slot_ok_q) begin
						evt.has_prim     = 1'b1;
						evt.prim_end     = 1'b1;
						evt.slot         = slot_lo_q;
						evt.name_present = seen_q;
						accepted_d       = accepted_q + CW'(1);
					end else begin
						rejected_d = rejected_q + CW'(1);
					end
					if ({{(32-CW){1'b0}}, parsed_d} == hc_q) begin
						phase_d = PH_DONE;
					end else begin
						pos_d   = 2'd0;
						phase_d = PH_SLOT;
					end
				end
			end
			default: begin
			end
		endcase

		if (last_byte) begin
			evt.has_sum   = 1'b1;
			evt.valid_res = (phase_d == PH_DONE);
			evt.declared  = (phase_d == PH_HEADER) ? 32'd0 : hc_d;
			evt.parsed    = parsed_d;
			evt.accepted  = accepted_d;
			evt.rejected  = rejected_d;
			phase_d       = PH_HEADER;
			pos_d         = 2'd0;
			hc_d          = '0;
			slot_lo_d     = '0;
			slot_hi_d     = 1'b0;
			slot_ok_d     = 1'b0;
			seen_d        = 1'b0;
			parsed_d      = '0;
			accepted_d    = '0;
			rejected_d    = '0;
		end
	end

	assign evt_push = take && (evt.has_prim || evt.has_sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			pos_q      <= '0;
			hc_q       <= '0;
			slot_lo_q  <= '0;
			slot_hi_q  <= 1'b0;
			slot_ok_q  <= 1'b0;
			seen_q     <= 1'b0;
			parsed_q   <= '0;
			accepted_q <= '0;
			rejected_q <= '0;
		end else if (take) begin
			phase_q    <= phase_d;
			pos_q      <= pos_d;
			hc_q       <= hc_d;
			slot_lo_q  <= slot_lo_d;
			slot_hi_q  <= slot_hi_d;
			slot_ok_q  <= slot_ok_d;
			seen_q     <= seen_d;
			parsed_q   <= parsed_d;
			accepted_q <= accepted_d;
			rejected_q <= rejected_d;
		end
	end

	// A final byte always leaves the parser ready for a fresh header.
	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		take && last_byte |=> phase_q == PH_HEADER && parsed_q == '0 && pos_q == 2'd0)
		else $error("parser did not return to header after final byte");

	// Entry counts stay consistent: every parsed entry was accepted or rejected.
	a_count_split: assert property (@(posedge clk) disable iff (!arst_n)
		parsed_q == accepted_q + rejected_q)
		else $error("parsed count differs from accepted plus rejected");

endmodule

// File: hw/rtl/slnp_queue.sv
// Short register queue of result records between the parser front and the output back.
// Depends on slnp_pkg for the record type.
module slnp_queue #(
	parameter int DEPTH = slnp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  slnp_pkg::evt_t wr_evt,
	input  logic           rd_en,
	output slnp_pkg::evt_t rd_evt,
	output logic           q_full,
	output logic           q_empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNW = $clog2(DEPTH + 1);

	slnp_pkg::evt_t  mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNW-1:0]  count_q;
	logic            do_wr, do_rd;

	assign q_full  = (count_q == CNW'(DEPTH));
	assign q_empty = (count_q == '0);
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_evt  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_evt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + CNW'(1);
				2'b01:   count_q <= count_q - CNW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNW'(DEPTH))
		else $error("queue occupancy beyond depth");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		do_wr && !do_rd |=> count_q == $past(count_q) + CNW'(1))
		else $error("queue occupancy lost a write");

endmodule

// File: hw/rtl/slnp_back.sv
// Back end: unpacks each queued record into one or two result beats on the output ports.
// Depends on slnp_pkg.
module slnp_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  slnp_pkg::evt_t                   head,
	input  logic                             q_empty,
	input  logic                             pop,
	output logic                             q_rd,
	output logic [1:0]                       kind,
	output logic [7:0]                       slot,
	output logic [7:0]                       name_char,
	output logic                             name_present,
	output logic                             valid_res,
	output logic [31:0]                      declared_count,
	output logic [slnp_pkg::CNT_W-1:0]       parsed_count,
	output logic [slnp_pkg::CNT_W-1:0]       accepted_count,
	output logic [slnp_pkg::CNT_W-1:0]       rejected_count,
	output logic                             last_result
);

	// Set once the entry beat of a two-beat record has gone out.
	logic sum_sel_q;
	logic show_prim;

	assign show_prim = head.has_prim && !sum_sel_q;

	always_comb begin
		kind           = slnp_pkg::KIND_SUM;
		slot           = '0;
		name_char      = '0;
		name_present   = 1'b0;
		valid_res      = 1'b0;
		declared_count = '0;
		parsed_count   = '0;
		accepted_count = '0;
		rejected_count = '0;
		last_result    = 1'b1;
		if (show_prim) begin
			kind         = head.prim_end ? slnp_pkg::KIND_END : slnp_pkg::KIND_CHAR;
			slot         = head.slot;
			name_char    = head.prim_end ? 8'd0 : head.name_char;
			name_present = head.prim_end && head.name_present;
			last_result  = !head.has_sum;
		end else begin
			valid_res      = head.valid_res;
			declared_count = head.declared;
			parsed_count   = head.parsed;
			accepted_count = head.accepted;
			rejected_count = head.rejected;
		end
	end

	assign q_rd = pop && !q_empty && last_result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_sel_q <= 1'b0;
		end else if (pop && !q_empty) begin
			sum_sel_q <= !last_result;
		end
	end

	a_sum_sel_legal: assert property (@(posedge clk) disable iff (!arst_n)
		sum_sel_q && !q_empty |-> head.has_prim && head.has_sum)
		else $error("second beat selected on a single-beat record");

endmodule
